### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent assertions used by the checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/qtb_pkg.sv
// ----------------------------------------------------------------------------
// qtb_pkg
// Node codes, line table and shared flag type of the triangle basis pipeline.
// ----------------------------------------------------------------------------
package qtb_pkg;

	// node codes; codes 0 to 5 also index the six nodes of the element
	localparam logic [2:0] NODE_P1  = 3'd0;
	localparam logic [2:0] NODE_P2  = 3'd1;
	localparam logic [2:0] NODE_P3  = 3'd2;
	localparam logic [2:0] NODE_M12 = 3'd3;
	localparam logic [2:0] NODE_M23 = 3'd4;
	localparam logic [2:0] NODE_M13 = 3'd5;
	localparam logic [2:0] NODE_NONE = 3'd6;

	// flags that travel with an item through the back half
	typedef struct packed {
		logic none;   // no node selected
		logic zero;   // divisor was zero
		logic neg;    // quotient negative
		logic ovf;    // quotient beyond result range
	} qtb_flags_t;

	// end points of the two lines for a node: k = 0,1 first line, 2,3 second
	function automatic logic [2:0] line_pt(input logic [2:0] nd, input logic [1:0] k);
		logic [2:0] p0, p1, p2, p3, res;
		unique case (nd)
			NODE_P1:  begin p0 = NODE_P2; p1 = NODE_P3; p2 = NODE_M12; p3 = NODE_M13; end
			NODE_P2:  begin p0 = NODE_P1; p1 = NODE_P3; p2 = NODE_M12; p3 = NODE_M23; end
			NODE_P3:  begin p0 = NODE_P1; p1 = NODE_P2; p2 = NODE_M23; p3 = NODE_M13; end
			NODE_M12: begin p0 = NODE_P2; p1 = NODE_P3; p2 = NODE_P1;  p3 = NODE_P3;  end
			NODE_M23: begin p0 = NODE_P1; p1 = NODE_P3; p2 = NODE_P1;  p3 = NODE_P2;  end
			NODE_M13: begin p0 = NODE_P2; p1 = NODE_P3; p2 = NODE_P1;  p3 = NODE_P2;  end
			default:  begin p0 = NODE_P1; p1 = NODE_P1; p2 = NODE_P1;  p3 = NODE_P1;  end
		endcase
		case (k)
			2'd0:    res = p0;
			2'd1:    res = p1;
			2'd2:    res = p2;
			default: res = p3;
		endcase
		return res;
	endfunction

endpackage

### rtl/core/quadratic_triangle_basis_eval.sv
// ----------------------------------------------------------------------------
// quadratic_triangle_basis_eval
// Six-node triangle shape function value at a query point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_ready   | corner1..3 x/y, query x/y, node
//  out     | out_valid / out_ready | basis_value, divide_fault
//
// One request accepted per cycle while the output is not stalled; the path runs
// through 3 geometry stages, 4 product stages, one divider stage per
// quotient bit (RESULT_WIDTH + 1) and the output register.
// Reset clears only the valid bits of every stage.
// A stall holds each full stage whose successor is held; bubbles close up.
// ----------------------------------------------------------------------------
module quadratic_triangle_basis_eval #(
	parameter int COORD_WIDTH  = 16,
	parameter int RESULT_WIDTH = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [COORD_WIDTH-1:0]   corner1_x,
	input  logic signed [COORD_WIDTH-1:0]   corner1_y,
	input  logic signed [COORD_WIDTH-1:0]   corner2_x,
	input  logic signed [COORD_WIDTH-1:0]   corner2_y,
	input  logic signed [COORD_WIDTH-1:0]   corner3_x,
	input  logic signed [COORD_WIDTH-1:0]   corner3_y,
	input  logic signed [COORD_WIDTH-1:0]   query_x,
	input  logic signed [COORD_WIDTH-1:0]   query_y,
	input  logic [2:0]                      node,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [RESULT_WIDTH-1:0]  basis_value,
	output logic                            divide_fault
);
	import qtb_pkg::*;

	localparam int LW = 2 * COORD_WIDTH + 5;
	localparam int PW = 4 * COORD_WIDTH + 10;

	logic                 f_valid, f_ready;
	logic signed [LW-1:0] ln0, ln1, lq0, lq1;
	logic                 none;
	logic                 p_valid, p_ready;
	logic [PW-1:0]        rem0, den;
	logic [RESULT_WIDTH:0] num_lo;
	qtb_flags_t           flags;

	// line values at node and query point
	qtb_front #(.CW(COORD_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.corner1_x(corner1_x), .corner1_y(corner1_y),
		.corner2_x(corner2_x), .corner2_y(corner2_y),
		.corner3_x(corner3_x), .corner3_y(corner3_y),
		.query_x(query_x), .query_y(query_y), .node(node),
		.out_valid(f_valid), .out_ready(f_ready),
		.ln0(ln0), .ln1(ln1), .lq0(lq0), .lq1(lq1), .none(none)
	);

	// products and divider set-up
	qtb_prod #(.CW(COORD_WIDTH), .RW(RESULT_WIDTH)) u_prod (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready),
		.ln0(ln0), .ln1(ln1), .lq0(lq0), .lq1(lq1), .none(none),
		.out_valid(p_valid), .out_ready(p_ready),
		.rem0(rem0), .num_lo(num_lo), .den(den), .flags(flags)
	);

	// quotient, rounding and saturation
	qtb_div #(.CW(COORD_WIDTH), .RW(RESULT_WIDTH)) u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(p_valid), .in_ready(p_ready),
		.rem0(rem0), .num_lo(num_lo), .den(den), .flags(flags),
		.out_valid(out_valid), .out_ready(out_ready),
		.basis_value(basis_value), .divide_fault(divide_fault)
	);

endmodule

### rtl/core/qtb_front.sv
// ----------------------------------------------------------------------------
// qtb_front
// Node geometry and the four line values (two lines, at node and at query).
// ----------------------------------------------------------------------------
module qtb_front #(
	parameter int CW = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [CW-1:0]     corner1_x,
	input  logic signed [CW-1:0]     corner1_y,
	input  logic signed [CW-1:0]     corner2_x,
	input  logic signed [CW-1:0]     corner2_y,
	input  logic signed [CW-1:0]     corner3_x,
	input  logic signed [CW-1:0]     corner3_y,
	input  logic signed [CW-1:0]     query_x,
	input  logic signed [CW-1:0]     query_y,
	input  logic [2:0]               node,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [2*CW+4:0]   ln0,
	output logic signed [2*CW+4:0]   ln1,
	output logic signed [2*CW+4:0]   lq0,
	output logic signed [2*CW+4:0]   lq1,
	output logic                     none
);
	import qtb_pkg::*;

	localparam int PTW = CW + 1;
	localparam int DFW = CW + 2;
	localparam int TW  = 2 * CW + 4;
	localparam int LW  = 2 * CW + 5;

	logic signed [PTW-1:0] px [6];
	logic signed [PTW-1:0] py [6];
	logic signed [PTW-1:0] qx, qy, nx, ny;
	logic [2:0] ia [2];
	logic [2:0] ib [2];
	logic [2:0] nd;

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;
	logic signed [DFW-1:0] dx_s1 [2];
	logic signed [DFW-1:0] dy_s1 [2];
	logic signed [DFW-1:0] enx_s1 [2];
	logic signed [DFW-1:0] eny_s1 [2];
	logic signed [DFW-1:0] eqx_s1 [2];
	logic signed [DFW-1:0] eqy_s1 [2];
	logic none_s1, none_s2, none_s3;
	logic signed [TW-1:0] tn1_s2 [2];
	logic signed [TW-1:0] tn2_s2 [2];
	logic signed [TW-1:0] tq1_s2 [2];
	logic signed [TW-1:0] tq2_s2 [2];
	logic signed [LW-1:0] ln_s3 [2];
	logic signed [LW-1:0] lq_s3 [2];

	// stall chain
	assign en3 = !v_s3 || out_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	// doubled corners, midpoints, line end points
	always_comb begin
		px[0] = {corner1_x, 1'b0};
		py[0] = {corner1_y, 1'b0};
		px[1] = {corner2_x, 1'b0};
		py[1] = {corner2_y, 1'b0};
		px[2] = {corner3_x, 1'b0};
		py[2] = {corner3_y, 1'b0};
		px[3] = PTW'(corner1_x) + PTW'(corner2_x);
		py[3] = PTW'(corner1_y) + PTW'(corner2_y);
		px[4] = PTW'(corner2_x) + PTW'(corner3_x);
		py[4] = PTW'(corner2_y) + PTW'(corner3_y);
		px[5] = PTW'(corner1_x) + PTW'(corner3_x);
		py[5] = PTW'(corner1_y) + PTW'(corner3_y);
		qx = {query_x, 1'b0};
		qy = {query_y, 1'b0};
		nd = (node > NODE_M13) ? NODE_P1 : node;
		nx = px[nd];
		ny = py[nd];
		ia[0] = line_pt(node, 2'd0);
		ib[0] = line_pt(node, 2'd1);
		ia[1] = line_pt(node, 2'd2);
		ib[1] = line_pt(node, 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// stage 1: differences against the first end point of each line
	always_ff @(posedge clk) begin
		if (en1) begin
			none_s1 <= (node > NODE_M13);
			for (int j = 0; j < 2; j++) begin
				dx_s1[j]  <= DFW'(px[ib[j]]) - DFW'(px[ia[j]]);
				dy_s1[j]  <= DFW'(py[ib[j]]) - DFW'(py[ia[j]]);
				enx_s1[j] <= DFW'(nx) - DFW'(px[ia[j]]);
				eny_s1[j] <= DFW'(ny) - DFW'(py[ia[j]]);
				eqx_s1[j] <= DFW'(qx) - DFW'(px[ia[j]]);
				eqy_s1[j] <= DFW'(qy) - DFW'(py[ia[j]]);
			end
		end
	end

	// stage 2: cross product terms
	always_ff @(posedge clk) begin
		if (en2) begin
			none_s2 <= none_s1;
			for (int j = 0; j < 2; j++) begin
				tn1_s2[j] <= enx_s1[j] * dy_s1[j];
				tn2_s2[j] <= eny_s1[j] * dx_s1[j];
				tq1_s2[j] <= eqx_s1[j] * dy_s1[j];
				tq2_s2[j] <= eqy_s1[j] * dx_s1[j];
			end
		end
	end

	// stage 3: line values
	always_ff @(posedge clk) begin
		if (en3) begin
			none_s3 <= none_s2;
			for (int j = 0; j < 2; j++) begin
				ln_s3[j] <= LW'(tn1_s2[j]) - LW'(tn2_s2[j]);
				lq_s3[j] <= LW'(tq1_s2[j]) - LW'(tq2_s2[j]);
			end
		end
	end

	assign out_valid = v_s3;
	assign ln0 = ln_s3[0];
	assign ln1 = ln_s3[1];
	assign lq0 = lq_s3[0];
	assign lq1 = lq_s3[1];
	assign none = none_s3;

endmodule

### rtl/core/qtb_prod.sv
// ----------------------------------------------------------------------------
// qtb_prod
// Products of the line pairs, magnitudes, flags and divider set-up.
// ----------------------------------------------------------------------------
module qtb_prod #(
	parameter int CW = 16,
	parameter int RW = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [2*CW+4:0]      ln0,
	input  logic signed [2*CW+4:0]      ln1,
	input  logic signed [2*CW+4:0]      lq0,
	input  logic signed [2*CW+4:0]      lq1,
	input  logic                        none,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [4*CW+9:0]             rem0,
	output logic [RW:0]                 num_lo,
	output logic [4*CW+9:0]             den,
	output qtb_pkg::qtb_flags_t         flags
);
	import qtb_pkg::*;

	localparam int LW   = 2 * CW + 5;
	localparam int SPL  = LW / 2;
	localparam int HW   = LW - SPL;
	localparam int PPW  = LW + SPL + 1;
	localparam int PW   = 2 * LW;
	localparam int FB   = CW - 2;
	localparam int Q    = RW + 1;
	localparam int NW   = PW + FB + 1;
	localparam int CMPW = NW + Q + 1;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	logic signed [SPL:0]    dlo, nlo;
	logic signed [HW-1:0]   dhi, nhi;
	logic signed [PPW-1:0]  dpl_s1, dph_s1, npl_s1, nph_s1;
	logic none_s1, none_s2, none_s3;
	logic signed [PW-1:0]   den_s2, num_s2;
	logic [PW-1:0]          dab_s3, nab_s3;
	logic zero_s3, neg_s3;
	logic [NW-1:0]          nsh;
	logic [PW-1:0]          rem_s4, den_s4;
	logic [Q-1:0]           nlo_s4;
	qtb_flags_t             fl_s4;

	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// split the second factor into an unsigned low and a signed high half
	assign dlo = $signed({1'b0, ln1[SPL-1:0]});
	assign nlo = $signed({1'b0, lq1[SPL-1:0]});
	assign dhi = ln1[LW-1:SPL];
	assign nhi = lq1[LW-1:SPL];

	// stage 1: partial products
	always_ff @(posedge clk) begin
		if (en1) begin
			none_s1 <= none;
			dpl_s1  <= ln0 * dlo;
			dph_s1  <= ln0 * dhi;
			npl_s1  <= lq0 * nlo;
			nph_s1  <= lq0 * nhi;
		end
	end

	// stage 2: recombine
	always_ff @(posedge clk) begin
		if (en2) begin
			none_s2 <= none_s1;
			den_s2  <= (PW'(dph_s1) <<< SPL) + PW'(dpl_s1);
			num_s2  <= (PW'(nph_s1) <<< SPL) + PW'(npl_s1);
		end
	end

	// stage 3: magnitudes and sign
	always_ff @(posedge clk) begin
		if (en3) begin
			none_s3 <= none_s2;
			zero_s3 <= (den_s2 == '0);
			neg_s3  <= den_s2[PW-1] ^ num_s2[PW-1];
			dab_s3  <= den_s2[PW-1] ? PW'(-den_s2) : PW'(den_s2);
			nab_s3  <= num_s2[PW-1] ? PW'(-num_s2) : PW'(num_s2);
		end
	end

	// stage 4: range check and first partial remainder
	assign nsh = NW'(nab_s3) << (FB + 1);

	always_ff @(posedge clk) begin
		if (en4) begin
			fl_s4.none <= none_s3;
			fl_s4.zero <= zero_s3;
			fl_s4.neg  <= neg_s3;
			fl_s4.ovf  <= (CMPW'(nsh) >= (CMPW'(dab_s3) << Q));
			rem_s4     <= PW'(nsh >> Q);
			nlo_s4     <= nsh[Q-1:0];
			den_s4     <= dab_s3;
		end
	end

	assign out_valid = v_s4;
	assign rem0   = rem_s4;
	assign num_lo = nlo_s4;
	assign den    = den_s4;
	assign flags  = fl_s4;

endmodule

### rtl/core/qtb_div.sv
// ----------------------------------------------------------------------------
// qtb_div
// Restoring divider, one quotient bit per stage, then rounding and clamping.
// ----------------------------------------------------------------------------
module qtb_div #(
	parameter int CW = 16,
	parameter int RW = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [4*CW+9:0]             rem0,
	input  logic [RW:0]                 num_lo,
	input  logic [4*CW+9:0]             den,
	input  qtb_pkg::qtb_flags_t         flags,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [RW-1:0]        basis_value,
	output logic                        divide_fault
);
	import qtb_pkg::*;

	localparam int PW = 4 * CW + 10;
	localparam int Q  = RW + 1;
	localparam logic [Q-1:0] LIM_POS = Q'((64'd1 << (RW - 1)) - 64'd1);
	localparam logic [Q-1:0] LIM_NEG = Q'(64'd1 << (RW - 1));

	logic              v  [0:Q];
	logic [PW-1:0]     r  [0:Q];
	logic [Q-1:0]      nl [0:Q];
	logic [Q-1:0]      qq [0:Q];
	logic [PW-1:0]     d  [0:Q];
	qtb_flags_t        fl [0:Q];
	logic              en [1:Q+1];

	logic              vo_q;
	logic signed [RW-1:0] val_q;
	logic              flt_q;
	logic [Q:0]        rsum;
	logic [Q-1:0]      mag, lim, magc;

	assign v[0]  = in_valid;
	assign r[0]  = rem0;
	assign nl[0] = num_lo;
	assign qq[0] = '0;
	assign d[0]  = den;
	assign fl[0] = flags;
	assign in_ready = en[1];
	assign en[Q+1] = !vo_q || out_ready;

	// one quotient bit per stage
	for (genvar i = 1; i <= Q; i++) begin : g_stage
		logic [PW:0] t;
		logic        ge;
		logic [PW:0] diff;
		assign t    = {r[i-1], nl[i-1][Q-1]};
		assign ge   = (t >= {1'b0, d[i-1]});
		assign diff = t - {1'b0, d[i-1]};
		assign en[i] = !v[i] || en[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v[i] <= 1'b0;
			end else if (en[i]) begin
				v[i] <= v[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				r[i]  <= ge ? diff[PW-1:0] : t[PW-1:0];
				nl[i] <= nl[i-1] << 1;
				qq[i] <= {qq[i-1][Q-2:0], ge};
				d[i]  <= d[i-1];
				fl[i] <= fl[i-1];
			end
		end
	end

	// round half away from zero, clamp, apply sign
	always_comb begin
		rsum = {1'b0, qq[Q]} + (Q+1)'(1);
		mag  = rsum[Q:1];
		lim  = fl[Q].neg ? LIM_NEG : LIM_POS;
		magc = (fl[Q].ovf || (mag > lim)) ? lim : mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (en[Q+1]) begin
			vo_q <= v[Q];
		end
	end

	always_ff @(posedge clk) begin
		if (en[Q+1]) begin
			if (fl[Q].none || fl[Q].zero) begin
				val_q <= '0;
			end else if (fl[Q].neg) begin
				val_q <= RW'(-magc);
			end else begin
				val_q <= RW'(magc);
			end
			flt_q <= !fl[Q].none && fl[Q].zero;
		end
	end

	assign out_valid    = vo_q;
	assign basis_value  = val_q;
	assign divide_fault = flt_q;

endmodule

### rtl/core/qtb_checker.sv
// ----------------------------------------------------------------------------
// qtb_checker
// Port-level checks of the triangle basis pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qtb_checker #(
	parameter int RESULT_WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_ready,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic [RESULT_WIDTH-1:0]  basis_value,
	input  logic                     divide_fault
);

	// a held result keeps its payload
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(basis_value) && $stable(divide_fault), "result changed while stalled")

	// a zero divisor always reports a zero value
	`ASSERT_IMPL(a_fault_zero, clk, arst_n, out_valid && divide_fault, basis_value == '0, "fault with nonzero value")

	// with the sink ready the whole pipeline moves, so input is taken
	`ASSERT_IMPL(a_flow, clk, arst_n, out_ready, in_ready, "input blocked with free output")

endmodule

bind quadratic_triangle_basis_eval qtb_checker #(.RESULT_WIDTH(RESULT_WIDTH)) u_qtb_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .basis_value(basis_value), .divide_fault(divide_fault)
);
